// ----- hdl/hot_pkg.sv -----
// Heating override timer package: event codes, selection codes, decision codes
// and the fixed limits and reset values of the timer.
// No dependencies.
`default_nettype none

package hot_pkg;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int TEMP_W     = 8;
    localparam int DEC_W      = 2;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SEL_W      = 2;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Limits and reset values
    localparam logic [HOUR_W-1:0]     HOUR_MAX       = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0]   MINUTE_MAX     = MINUTE_W'(59);
    localparam logic [HOUR_W-1:0]     HOUR_DEFAULT   = HOUR_W'(1);
    localparam logic [TEMP_W-1:0]     TEMP_RESET_MAX = TEMP_W'(28);
    localparam logic [CFG_DATA_W-1:0] IDLE_RESET     = CFG_DATA_W'(30);

    // Input events
    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT_VALUE  = 3'd0,
        CMD_NEXT_ACTION = 3'd1,
        CMD_APPLY       = 3'd2,
        CMD_MINUTE_TICK = 3'd3,
        CMD_SECOND_TICK = 3'd4,
        CMD_SET_TEMP    = 3'd5
    } t_cmd;

    // Selected value
    typedef enum logic [SEL_W-1:0] {
        SEL_NONE   = 2'd0,
        SEL_TEMP   = 2'd1,
        SEL_HOUR   = 2'd2,
        SEL_MINUTE = 2'd3
    } t_sel;

    // Selected action
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_PLUS    = 3'd1,
        ACT_MINUS   = 3'd2,
        ACT_DEFAULT = 3'd3,
        ACT_CLEAR   = 3'd4
    } t_action;

    // Override decision
    typedef enum logic [DEC_W-1:0] {
        DEC_NONE     = 2'd0,
        DEC_HEAT_ON  = 2'd1,
        DEC_HEAT_OFF = 2'd2
    } t_decision;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_TIMEOUT = 1'b0,
        CFG_MAX_TEMP     = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- hdl/heating_override_timer.sv -----
// Heating override timer: button-driven override editor, countdown timer,
// idle timeout and heat decision. Depends on hot_pkg.
//
// An input transfer's result is registered and shown in the next cycle; one
// event per cycle is taken while the result side is ready, the next entering
// as the result register is emptied. Synchronous active-low reset restores
// the timeout (30 s) and temperature limit (28) registers, clears selections
// and override settings, and rearms the idle timer with the backlight on.
`default_nettype none

module heating_override_timer (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire [hot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [hot_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // event channel
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [hot_pkg::CMD_W-1:0]          i_cmd,
    input  wire [hot_pkg::TEMP_W-1:0]         i_temperature,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [hot_pkg::DEC_W-1:0]         o_decision,
    output logic                              o_decision_valid,
    output logic [hot_pkg::TEMP_W-1:0]        o_override_temp,
    output logic [hot_pkg::HOUR_W-1:0]        o_override_hour,
    output logic [hot_pkg::MINUTE_W-1:0]      o_override_minute,
    output logic [hot_pkg::SEL_W-1:0]         o_selected_value,
    output logic [hot_pkg::ACT_W-1:0]         o_selected_action,
    output logic                              o_backlight,
    output logic                              o_settings_changed
);
    import hot_pkg::*;

    // Configuration
    logic [CFG_DATA_W-1:0] r_idle_timeout;
    logic [TEMP_W-1:0]     r_max_temp;

    // Controller state
    t_sel                  r_value_sel,   n_value_sel;
    t_action               r_action_sel,  n_action_sel;
    logic [TEMP_W-1:0]     r_target_temp, n_target_temp;
    logic [HOUR_W-1:0]     r_hours_left,  n_hours_left;
    logic [MINUTE_W-1:0]   r_minutes_left, n_minutes_left;
    logic [TEMP_W-1:0]     r_measured,    n_measured;
    logic [CFG_DATA_W-1:0] r_idle_left,   n_idle_left;
    logic                  r_idle_armed,  n_idle_armed;
    logic                  r_light_on,    n_light_on;

    // Result register (fields that are not plain state)
    logic                  r_out_valid;
    t_decision             r_decision,    n_decision;
    logic                  r_dec_valid,   n_dec_valid;
    logic                  r_changed,     n_changed;

    logic                  in_xfer;
    logic                  restart_idle;
    logic                  edit_ok;
    t_cmd                  cmd;

    assign cmd        = t_cmd'(i_cmd);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Next state for one event
    always_comb begin
        n_value_sel    = r_value_sel;
        n_action_sel   = r_action_sel;
        n_target_temp  = r_target_temp;
        n_hours_left   = r_hours_left;
        n_minutes_left = r_minutes_left;
        n_measured     = r_measured;
        n_idle_left    = r_idle_left;
        n_idle_armed   = r_idle_armed;
        n_light_on     = r_light_on;
        n_dec_valid    = 1'b0;
        n_changed      = 1'b0;
        restart_idle   = 1'b0;
        edit_ok        = (r_value_sel != SEL_NONE) && (r_action_sel != ACT_NONE);

        case (cmd)
            CMD_NEXT_VALUE: begin
                n_value_sel  = t_sel'(r_value_sel + SEL_W'(1));
                n_action_sel = ACT_NONE;
                restart_idle = 1'b1;
            end
            CMD_NEXT_ACTION: begin
                if (r_action_sel inside {[ACT_CLEAR:3'd7]}) begin
                    n_action_sel = ACT_NONE;
                end else begin
                    n_action_sel = t_action'(r_action_sel + ACT_W'(1));
                end
                restart_idle = 1'b1;
            end
            CMD_APPLY: begin
                restart_idle = 1'b1;
                if (edit_ok) begin
                    n_changed   = 1'b1;
                    n_dec_valid = 1'b1;
                    case (r_value_sel)
                        SEL_TEMP: begin
                            case (r_action_sel)
                                ACT_PLUS: begin
                                    if (r_target_temp < r_max_temp)
                                        n_target_temp = r_target_temp + TEMP_W'(1);
                                end
                                ACT_MINUS: begin
                                    if (r_target_temp != '0)
                                        n_target_temp = r_target_temp - TEMP_W'(1);
                                end
                                ACT_DEFAULT: n_target_temp = r_measured;
                                default:     n_target_temp = '0;
                            endcase
                        end
                        SEL_HOUR: begin
                            case (r_action_sel)
                                ACT_PLUS: begin
                                    if (r_hours_left < HOUR_MAX)
                                        n_hours_left = r_hours_left + HOUR_W'(1);
                                end
                                ACT_MINUS: begin
                                    if (r_hours_left != '0)
                                        n_hours_left = r_hours_left - HOUR_W'(1);
                                end
                                ACT_DEFAULT: n_hours_left = HOUR_DEFAULT;
                                default:     n_hours_left = '0;
                            endcase
                        end
                        default: begin
                            // minutes: default behaves as clear
                            case (r_action_sel)
                                ACT_PLUS: begin
                                    if (r_minutes_left < MINUTE_MAX)
                                        n_minutes_left = r_minutes_left + MINUTE_W'(1);
                                end
                                ACT_MINUS: begin
                                    if (r_minutes_left != '0)
                                        n_minutes_left = r_minutes_left - MINUTE_W'(1);
                                end
                                default: n_minutes_left = '0;
                            endcase
                        end
                    endcase
                end
            end
            CMD_MINUTE_TICK: begin
                n_dec_valid = 1'b1;
                if (r_minutes_left != '0) begin
                    n_minutes_left = r_minutes_left - MINUTE_W'(1);
                    n_changed      = 1'b1;
                end else if (r_hours_left != '0) begin
                    // borrow an hour
                    n_hours_left   = r_hours_left - HOUR_W'(1);
                    n_minutes_left = MINUTE_MAX;
                    n_changed      = 1'b1;
                end
            end
            CMD_SECOND_TICK: begin
                if (r_idle_armed) begin
                    if (r_idle_left <= CFG_DATA_W'(1)) begin
                        // idle expiry
                        n_idle_left  = '0;
                        n_idle_armed = 1'b0;
                        n_value_sel  = SEL_NONE;
                        n_action_sel = ACT_NONE;
                        n_light_on   = 1'b0;
                    end else begin
                        n_idle_left = r_idle_left - CFG_DATA_W'(1);
                    end
                end
            end
            CMD_SET_TEMP: begin
                n_measured = i_temperature;
            end
            default: begin
            end
        endcase

        if (restart_idle) begin
            n_idle_left  = r_idle_timeout;
            n_idle_armed = 1'b1;
            n_light_on   = 1'b1;
        end
    end

    // Decision on the updated override settings
    always_comb begin
        n_decision = DEC_NONE;
        if (n_dec_valid && (n_target_temp != '0) &&
            ((n_hours_left != '0) || (n_minutes_left != '0))) begin
            n_decision = (n_measured < n_target_temp) ? DEC_HEAT_ON : DEC_HEAT_OFF;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_RESET;
            r_max_temp     <= TEMP_RESET_MAX;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data;
                CFG_MAX_TEMP:     r_max_temp     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // State and result registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_sel    <= SEL_NONE;
            r_action_sel   <= ACT_NONE;
            r_target_temp  <= '0;
            r_hours_left   <= '0;
            r_minutes_left <= '0;
            r_measured     <= '0;
            r_idle_left    <= IDLE_RESET;
            r_idle_armed   <= 1'b1;
            r_light_on     <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_value_sel    <= n_value_sel;
                r_action_sel   <= n_action_sel;
                r_target_temp  <= n_target_temp;
                r_hours_left   <= n_hours_left;
                r_minutes_left <= n_minutes_left;
                r_measured     <= n_measured;
                r_idle_left    <= n_idle_left;
                r_idle_armed   <= n_idle_armed;
                r_light_on     <= n_light_on;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_decision  <= n_decision;
            r_dec_valid <= n_dec_valid;
            r_changed   <= n_changed;
        end
    end

    // Outputs show the state after the last transfer
    assign o_out_valid        = r_out_valid;
    assign o_decision         = r_decision;
    assign o_decision_valid   = r_dec_valid;
    assign o_settings_changed = r_changed;
    assign o_override_temp    = r_target_temp;
    assign o_override_hour    = r_hours_left;
    assign o_override_minute  = r_minutes_left;
    assign o_selected_value   = r_value_sel;
    assign o_selected_action  = r_action_sel;
    assign o_backlight        = r_light_on;

endmodule

`default_nettype wire

// ----- sim/heating_override_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for heating_override_timer. It mirrors the override editor, the countdown,
// the idle timeout and the decision, and checks every result transfer in order.
// Depends on hot_pkg.

module heating_override_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [hot_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [hot_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                             i_in_valid,
    input  wire                             i_in_ready,
    input  wire [hot_pkg::CMD_W-1:0]        i_cmd,
    input  wire [hot_pkg::TEMP_W-1:0]       i_temperature,
    input  wire                             i_out_valid,
    input  wire                             i_out_ready,
    input  wire [hot_pkg::DEC_W-1:0]        i_decision,
    input  wire                             i_decision_valid,
    input  wire [hot_pkg::TEMP_W-1:0]       i_override_temp,
    input  wire [hot_pkg::HOUR_W-1:0]       i_override_hour,
    input  wire [hot_pkg::MINUTE_W-1:0]     i_override_minute,
    input  wire [hot_pkg::SEL_W-1:0]        i_selected_value,
    input  wire [hot_pkg::ACT_W-1:0]        i_selected_action,
    input  wire                             i_backlight,
    input  wire                             i_settings_changed,
    output int                              o_fail_count,
    output int                              o_pending
);
    import hot_pkg::*;

    // One result transfer as the block reports it
    typedef struct packed {
        t_decision             decision;
        logic                  decision_valid;
        logic [TEMP_W-1:0]     target;
        logic [HOUR_W-1:0]     hours;
        logic [MINUTE_W-1:0]   minutes;
        t_sel                  value;
        t_action               action;
        logic                  backlight;
        logic                  changed;
    } t_status;

    t_status pending_status[$];
    t_status predicted;
    int      mismatches = 0;

    // Mirrored configuration and state
    logic [CFG_DATA_W-1:0] idle_timeout;
    logic [TEMP_W-1:0]     temp_limit;
    t_sel                  value_sel;
    t_action               action_sel;
    logic [TEMP_W-1:0]     target_temp;
    logic [HOUR_W-1:0]     hours_left;
    logic [MINUTE_W-1:0]   minutes_left;
    logic [TEMP_W-1:0]     measured_temp;
    logic [CFG_DATA_W-1:0] idle_count;
    logic                  idle_armed;
    logic                  backlight_on;

    // Heat on while below target, off when at or above; none without target or time
    function automatic t_decision heat_decision();
        if (target_temp != '0 && (hours_left != '0 || minutes_left != '0)) begin
            return (measured_temp < target_temp) ? DEC_HEAT_ON : DEC_HEAT_OFF;
        end
        return DEC_NONE;
    endfunction

    task automatic restart_idle_timer();
        idle_count   = idle_timeout;
        idle_armed   = 1'b1;
        backlight_on = 1'b1;
    endtask

    // Advance the mirror by one event and build the expected status
    task automatic step_override(input logic [CMD_W-1:0] cmd, input logic [TEMP_W-1:0] temp,
                                 output t_status res);
        logic      changed;
        logic      evaluated;
        t_decision dec;
        changed   = 1'b0;
        evaluated = 1'b0;
        dec       = DEC_NONE;
        case (cmd)
            CMD_NEXT_VALUE: begin
                value_sel  = t_sel'(value_sel + 1'b1);
                action_sel = ACT_NONE;
                restart_idle_timer();
            end
            CMD_NEXT_ACTION: begin
                action_sel = (action_sel == ACT_CLEAR) ? ACT_NONE : t_action'(action_sel + 1'b1);
                restart_idle_timer();
            end
            CMD_APPLY: begin
                restart_idle_timer();
                if (value_sel != SEL_NONE && action_sel != ACT_NONE) begin
                    case (value_sel)
                        SEL_TEMP: begin
                            case (action_sel)
                                ACT_PLUS:    if (target_temp < temp_limit) target_temp++;
                                ACT_MINUS:   if (target_temp != '0) target_temp--;
                                ACT_DEFAULT: target_temp = measured_temp;
                                default:     target_temp = '0;
                            endcase
                        end
                        SEL_HOUR: begin
                            case (action_sel)
                                ACT_PLUS:    if (hours_left < HOUR_MAX) hours_left++;
                                ACT_MINUS:   if (hours_left != '0) hours_left--;
                                ACT_DEFAULT: hours_left = HOUR_DEFAULT;
                                default:     hours_left = '0;
                            endcase
                        end
                        default: begin
                            // minutes: default and clear both give zero
                            case (action_sel)
                                ACT_PLUS:  if (minutes_left < MINUTE_MAX) minutes_left++;
                                ACT_MINUS: if (minutes_left != '0) minutes_left--;
                                default:   minutes_left = '0;
                            endcase
                        end
                    endcase
                    changed   = 1'b1;
                    evaluated = 1'b1;
                    dec       = heat_decision();
                end
            end
            CMD_MINUTE_TICK: begin
                // borrow an hour when the minutes run out
                if (minutes_left != '0) begin
                    minutes_left--;
                    changed = 1'b1;
                end else if (hours_left != '0) begin
                    hours_left--;
                    minutes_left = MINUTE_MAX;
                    changed      = 1'b1;
                end
                evaluated = 1'b1;
                dec       = heat_decision();
            end
            CMD_SECOND_TICK: begin
                if (idle_armed) begin
                    if (idle_count <= 1) begin
                        idle_count   = '0;
                        idle_armed   = 1'b0;
                        value_sel    = SEL_NONE;
                        action_sel   = ACT_NONE;
                        backlight_on = 1'b0;
                    end else begin
                        idle_count--;
                    end
                end
            end
            CMD_SET_TEMP: measured_temp = temp;
            default: ;
        endcase
        res.decision       = dec;
        res.decision_valid = evaluated;
        res.target         = target_temp;
        res.hours          = hours_left;
        res.minutes        = minutes_left;
        res.value          = value_sel;
        res.action         = action_sel;
        res.backlight      = backlight_on;
        res.changed        = changed;
    endtask

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    // Compare one result transfer against the oldest expectation
    task automatic check_status();
        t_status exp_st;
        if (pending_status.size() == 0) begin
            $error("result transfer with no expectation pending");
            mismatches++;
        end else begin
            exp_st = pending_status.pop_front();
            check_field("decision", exp_st.decision, i_decision);
            check_field("decision_valid", exp_st.decision_valid, i_decision_valid);
            check_field("override_temp", exp_st.target, i_override_temp);
            check_field("override_hour", exp_st.hours, i_override_hour);
            check_field("override_minute", exp_st.minutes, i_override_minute);
            check_field("selected_value", exp_st.value, i_selected_value);
            check_field("selected_action", exp_st.action, i_selected_action);
            check_field("backlight", exp_st.backlight, i_backlight);
            check_field("settings_changed", exp_st.changed, i_settings_changed);
        end
    endtask

    // Watch the channels; results leave before the same-edge event is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_timeout  = IDLE_RESET;
            temp_limit    = TEMP_RESET_MAX;
            value_sel     = SEL_NONE;
            action_sel    = ACT_NONE;
            target_temp   = '0;
            hours_left    = '0;
            minutes_left  = '0;
            measured_temp = '0;
            idle_count    = IDLE_RESET;
            idle_armed    = 1'b1;
            backlight_on  = 1'b1;
            pending_status.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_status();
            end
            if (i_in_valid && i_in_ready) begin
                step_override(i_cmd, i_temperature, predicted);
                pending_status.push_back(predicted);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDLE_TIMEOUT: idle_timeout = i_cfg_data;
                    CFG_MAX_TEMP:     temp_limit   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_status.size();
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Top of the heating_override_timer bench: clock, reset, event and register stimulus,
// result-side stalls and the verdict. Depends on hot_pkg and heating_override_checker.

module testbench;
    import hot_pkg::*;

    // Event codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 300;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic [CMD_W-1:0]      cmd         = '0;
    logic [TEMP_W-1:0]     temperature = '0;
    logic                  out_ready   = 1'b0;
    logic                  idle_bursts = 1'b0;
    int                    items_sent  = 0;

    logic                  in_ready;
    logic                  out_valid;
    logic [DEC_W-1:0]      decision;
    logic                  decision_valid;
    logic [TEMP_W-1:0]     override_temp;
    logic [HOUR_W-1:0]     override_hour;
    logic [MINUTE_W-1:0]   override_minute;
    logic [SEL_W-1:0]      selected_value;
    logic [ACT_W-1:0]      selected_action;
    logic                  backlight;
    logic                  settings_changed;
    int                    fail_count;
    int                    pending;

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    heating_override_timer i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_temperature      (temperature),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_decision         (decision),
        .o_decision_valid   (decision_valid),
        .o_override_temp    (override_temp),
        .o_override_hour    (override_hour),
        .o_override_minute  (override_minute),
        .o_selected_value   (selected_value),
        .o_selected_action  (selected_action),
        .o_backlight        (backlight),
        .o_settings_changed (settings_changed)
    );

    heating_override_checker u_scoreboard (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_cmd              (cmd),
        .i_temperature      (temperature),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_decision         (decision),
        .i_decision_valid   (decision_valid),
        .i_override_temp    (override_temp),
        .i_override_hour    (override_hour),
        .i_override_minute  (override_minute),
        .i_selected_value   (selected_value),
        .i_selected_action  (selected_action),
        .i_backlight        (backlight),
        .i_settings_changed (settings_changed),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Result side: random stall bursts while idling is allowed
    initial begin
        forever begin
            @(posedge clk);
            if (idle_bursts && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // One event transfer, with an optional idle burst ahead of it
    task automatic send_event(input logic [CMD_W-1:0] c, input logic [TEMP_W-1:0] t);
        int gap;
        gap = (idle_bursts && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        temperature <= t;
        do @(posedge clk); while (!in_ready);
        if (c <= CMD_SET_TEMP) items_sent++;
    endtask

    // Hold off events until every expected result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic program_limits(input logic [CFG_DATA_W-1:0] timeout,
                                  input logic [CFG_DATA_W-1:0] max_temp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDLE_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge clk);
        cfg_index <= CFG_MAX_TEMP;
        cfg_data  <= max_temp;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly select-and-apply sequences, plus ticks, samples and some noise
    task automatic random_events(input int n, input logic allow_idle);
        int stop_at;
        int kind;
        stop_at = items_sent + n;
        idle_bursts <= allow_idle;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                repeat ($urandom_range(0, 4))
                    send_event(CMD_NEXT_VALUE, TEMP_W'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 5))
                    send_event(CMD_NEXT_ACTION, TEMP_W'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 6))
                    send_event(CMD_APPLY, TEMP_W'($urandom_range(0, 255)));
            end else if (kind < 60) begin
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12))
                    send_event(CMD_MINUTE_TICK, TEMP_W'($urandom_range(0, 255)));
            end else if (kind < 72) begin
                send_event(CMD_SET_TEMP, $urandom_range(0, 1) ? TEMP_W'($urandom_range(0, 255))
                                                            : TEMP_W'($urandom_range(0, 40)));
            end else if (kind < 90) begin
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 260) : $urandom_range(1, 8))
                    send_event(CMD_SECOND_TICK, TEMP_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_event(CMD_W'($urandom_range(0, 7)), TEMP_W'($urandom_range(0, 255)));
            end
            if (allow_idle && $urandom_range(0, 19) == 0) begin
                idle_bursts <= ($urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [CFG_DATA_W-1:0] timeout;
        logic [CFG_DATA_W-1:0] max_temp;
        repeat (4) @(posedge clk);
        rst_n       <= 1'b1;
        idle_bursts <= 1'b1;

        // Directed: apply with nothing selected, minute tick at zero time, then edits
        send_event(CMD_APPLY, 8'd0);
        send_event(CMD_MINUTE_TICK, 8'd0);
        send_event(CMD_SET_TEMP, 8'd255);
        send_event(CMD_NEXT_VALUE, 8'd0);       // temperature
        send_event(CMD_NEXT_ACTION, 8'd0);      // plus
        send_event(CMD_APPLY, 8'd0);
        send_event(CMD_NEXT_ACTION, 8'd0);      // minus
        send_event(CMD_APPLY, 8'd0);
        send_event(CMD_APPLY, 8'd255);          // minus at zero
        send_event(CMD_NEXT_ACTION, 8'd0);      // default takes measured
        send_event(CMD_APPLY, 8'd0);
        send_event(CMD_NEXT_VALUE, 8'd0);       // hour, action cleared
        send_event(CMD_NEXT_ACTION, 8'd0);
        send_event(CMD_APPLY, 8'd0);
        send_event(CMD_MINUTE_TICK, 8'd0);      // borrow from the hour, heat off
        send_event(CMD_SET_TEMP, 8'd0);
        send_event(CMD_MINUTE_TICK, 8'd0);      // heat on
        send_event(CMD_NEXT_VALUE, 8'd0);       // minute
        send_event(CMD_NEXT_ACTION, 8'd0);
        send_event(CMD_APPLY, 8'd0);            // reaches the minute ceiling
        send_event(CMD_NEXT_VALUE, 8'd0);
        send_event(CMD_NEXT_VALUE, 8'd0);       // back to temperature
        send_event(CMD_NEXT_ACTION, 8'd0);
        send_event(CMD_APPLY, 8'd0);            // plus above the limit
        send_event(CMD_SPARE_A, 8'd255);
        send_event(CMD_SPARE_B, 8'd0);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            repeat (2) @(posedge clk);
            case (p)
                0: begin timeout = IDLE_RESET;               max_temp = TEMP_RESET_MAX; end
                1: begin timeout = 8'd1;                     max_temp = 8'd255;         end
                2: begin timeout = 8'd255;                   max_temp = 8'd1;           end
                3: begin timeout = 8'd0;                     max_temp = 8'd40;          end
                4: begin
                    timeout  = CFG_DATA_W'($urandom_range(1, 255));
                    max_temp = CFG_DATA_W'($urandom_range(1, 255));
                end
                default: begin timeout = 8'd3;               max_temp = TEMP_RESET_MAX; end
            endcase
            program_limits(timeout, max_temp);
            random_events(ITEMS_PER_PHASE, p != PHASES - 1);
        end

        wait_for_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hot_pkg.sv
hdl/heating_override_timer.sv
sim/heating_override_checker.sv
sim/testbench.sv
